@@ hw/rtl/psar_pkg.sv @@
`default_nettype none

package psar_pkg;

	localparam int unsigned ADDR_W = 15;
	localparam int unsigned FETCH_W = 14;
	localparam int unsigned KIND_W = 4;
	localparam int unsigned DATA_W = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_CTRL   = 4'd0,
		KIND_MASK   = 4'd1,
		KIND_SCROLL = 4'd2,
		KIND_ADDR   = 4'd3,
		KIND_STATUS = 4'd4,
		KIND_DATA   = 4'd5,
		KIND_INC_X  = 4'd6,
		KIND_INC_Y  = 4'd7,
		KIND_XFER_X = 4'd8,
		KIND_XFER_Y = 4'd9
	} psar_kind_t;

	// Address layout: coarse X [4:0], coarse Y [9:5], nametable X [10],
	// nametable Y [11], fine Y [14:12].
	typedef struct packed {
		logic [ADDR_W-1:0] v;
		logic [ADDR_W-1:0] t;
		logic [2:0]        fine_x;
		logic              toggle;
		logic              step_row;
		logic              render;
	} psar_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  address_before;
		logic [ADDR_W-1:0]  address_after;
		logic [FETCH_W-1:0] tile_fetch_address;
		logic [FETCH_W-1:0] attribute_fetch_address;
		logic [2:0]         attribute_shift;
		logic [2:0]         fine_x_scroll;
		logic [2:0]         fine_y_scroll;
		logic               toggle_after;
	} psar_result_t;

	localparam logic [4:0] COARSE_LAST = 5'd31;
	localparam logic [4:0] COARSE_Y_WRAP = 5'd29;
	localparam logic [2:0] FINE_LAST = 3'd7;

endpackage

`default_nettype wire

@@ hw/rtl/psar_if.sv @@
`default_nettype none

interface psar_item_if;
	logic       valid;
	logic       ready;
	logic [3:0] kind;
	logic [7:0] data;

	modport source (output valid, output kind, output data, input ready);
	modport sink (input valid, input kind, input data, output ready);
endinterface

interface psar_result_if;
	logic        valid;
	logic        ready;
	logic [14:0] address_before;
	logic [14:0] address_after;
	logic [13:0] tile_fetch_address;
	logic [13:0] attribute_fetch_address;
	logic [2:0]  attribute_shift;
	logic [2:0]  fine_x_scroll;
	logic [2:0]  fine_y_scroll;
	logic        toggle_after;

	modport source (output valid, output address_before, output address_after,
		output tile_fetch_address, output attribute_fetch_address,
		output attribute_shift, output fine_x_scroll, output fine_y_scroll,
		output toggle_after, input ready);
	modport sink (input valid, input address_before, input address_after,
		input tile_fetch_address, input attribute_fetch_address,
		input attribute_shift, input fine_x_scroll, input fine_y_scroll,
		input toggle_after, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/psar_step.sv @@
`default_nettype none

module psar_step
	import psar_pkg::*;
(
	input  psar_state_t       cur,
	input  logic [KIND_W-1:0] kind,
	input  logic [DATA_W-1:0] data,
	output psar_state_t       nxt
);

	logic [4:0] cy;

	assign cy = cur.v[9:5];

	always_comb begin
		nxt = cur;
		unique case (psar_kind_t'(kind))
			KIND_CTRL: begin
				nxt.t[11:10] = data[1:0];
				nxt.step_row = data[2];
			end
			KIND_MASK: begin
				nxt.render = data[3] | data[4];
			end
			KIND_SCROLL: begin
				if (!cur.toggle) begin
					nxt.fine_x = data[2:0];
					nxt.t[4:0] = data[7:3];
				end else begin
					nxt.t[14:12] = data[2:0];
					nxt.t[9:5] = data[7:3];
				end
				nxt.toggle = ~cur.toggle;
			end
			KIND_ADDR: begin
				if (!cur.toggle) begin
					nxt.t[14] = 1'b0;
					nxt.t[13:8] = data[5:0];
				end else begin
					nxt.t[7:0] = data;
					nxt.v = {cur.t[14:8], data};
				end
				nxt.toggle = ~cur.toggle;
			end
			KIND_STATUS: begin
				nxt.toggle = 1'b0;
			end
			KIND_DATA: begin
				nxt.v = cur.v + (cur.step_row ? 15'd32 : 15'd1);
			end
			KIND_INC_X: begin
				if (cur.render) begin
					if (cur.v[4:0] == COARSE_LAST) begin
						nxt.v[4:0] = 5'd0;
						nxt.v[10] = ~cur.v[10];
					end else begin
						nxt.v[4:0] = cur.v[4:0] + 5'd1;
					end
				end
			end
			KIND_INC_Y: begin
				if (cur.render) begin
					if (cur.v[14:12] != FINE_LAST) begin
						nxt.v[14:12] = cur.v[14:12] + 3'd1;
					end else begin
						nxt.v[14:12] = 3'd0;
						// Row 29 is the last tile row; rows 30 and 31 hold attributes,
						// and row 31 wraps to row 0 without switching nametables.
						if (cy == COARSE_Y_WRAP) begin
							nxt.v[9:5] = 5'd0;
							nxt.v[11] = ~cur.v[11];
						end else if (cy == COARSE_LAST) begin
							nxt.v[9:5] = 5'd0;
						end else begin
							nxt.v[9:5] = cy + 5'd1;
						end
					end
				end
			end
			KIND_XFER_X: begin
				if (cur.render) begin
					nxt.v[10] = cur.t[10];
					nxt.v[4:0] = cur.t[4:0];
				end
			end
			KIND_XFER_Y: begin
				if (cur.render) begin
					nxt.v[14:11] = cur.t[14:11];
					nxt.v[9:5] = cur.t[9:5];
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/psar_fetch.sv @@
`default_nettype none

module psar_fetch
	import psar_pkg::*;
(
	input  logic [ADDR_W-1:0] addr_prev,
	input  psar_state_t       nxt,
	output psar_result_t      res
);

	always_comb begin
		res.address_before = addr_prev;
		res.address_after = nxt.v;
		res.tile_fetch_address = {2'b10, nxt.v[11:0]};
		// Attribute table sits at offset 0x3C0 of the selected nametable.
		res.attribute_fetch_address = {2'b10, nxt.v[11:10], 4'b1111, nxt.v[9:7], nxt.v[4:2]};
		res.attribute_shift = {nxt.v[6], nxt.v[1], 1'b0};
		res.fine_x_scroll = nxt.fine_x;
		res.fine_y_scroll = nxt.v[14:12];
		res.toggle_after = nxt.toggle;
	end

endmodule

`default_nettype wire

@@ hw/rtl/ppu_scroll_address_registers_unit.sv @@
// Scroll and address register unit of a tile-based video chip.
// Items arrive on the item channel (kind, data) with a valid/ready
// handshake; each accepted transaction produces exactly one transaction
// on the result channel, in order.
// An accepted item is held in an input register. From there the register
// state is stepped and the result is computed from it, and both the state
// and the result register are loaded at the same edge.
// Throughput is one item per cycle while the receiver takes results: the
// input register is refilled in the same cycle it is emptied, and the whole
// step is one short path from the input register to the result register.
// When the receiver stalls, the result register holds, the input register
// keeps its item, and ready on the item channel drops once both are full.
// Asynchronous reset clears both registers' valid flags and all scroll
// state (current and temporary address, fine X, write toggle, increment
// mode, render enable) to zero.
`default_nettype none

module ppu_scroll_address_registers_unit
	import psar_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	psar_item_if.sink            item,
	psar_result_if.source        result
);

	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [DATA_W-1:0] data_s1;
	logic              valid_s2;
	psar_result_t      res_s2;
	psar_state_t       state_q;
	psar_state_t       state_nxt;
	psar_result_t      res_nxt;
	logic              advance;

	assign advance = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	psar_step u_step (
		.cur  (state_q),
		.kind (kind_s1),
		.data (data_s1),
		.nxt  (state_nxt)
	);

	psar_fetch u_fetch (
		.addr_prev (state_q.v),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1 <= item.kind;
			data_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid = valid_s2;
	assign result.address_before = res_s2.address_before;
	assign result.address_after = res_s2.address_after;
	assign result.tile_fetch_address = res_s2.tile_fetch_address;
	assign result.attribute_fetch_address = res_s2.attribute_fetch_address;
	assign result.attribute_shift = res_s2.attribute_shift;
	assign result.fine_x_scroll = res_s2.fine_x_scroll;
	assign result.fine_y_scroll = res_s2.fine_y_scroll;
	assign result.toggle_after = res_s2.toggle_after;

	// The published result must agree with the state it left behind.
	a_after_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (result.address_after == state_q.v
			&& result.toggle_after == state_q.toggle
			&& result.fine_x_scroll == state_q.fine_x))
		else $error("result does not match the updated state");

	// Each step starts from the address the previous step finished with.
	a_before_chain: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_nxt.address_before == state_q.v))
		else $error("address_before does not follow the current address");

	// A stalled item in the input register is never dropped.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(kind_s1) && $stable(data_s1)))
		else $error("pending item lost while stalled");

	// Render-time events leave the address alone while rendering is off; this check covers the coarse X increment.
	a_render_off: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !state_q.render && kind_s1 == KIND_INC_X) |=> $stable(state_q.v))
		else $error("coarse X increment acted with rendering off");

endmodule

`default_nettype wire
